// ===== design/llsr_pkg.sv =====
// Shared constants and types for the light level smoother and reporter.
`timescale 1ns / 1ps

package llsr_pkg;

   localparam int WINDOW = 3;

   localparam int MV_W   = 16;
   localparam int CODE_W = 8;
   localparam int AVG_W  = 8;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = AVG_W + CNT_W;
   localparam int PROD_W = MV_W + 8;
   localparam int LIM_W  = 20;
   localparam int STEP_W = $clog2(AVG_W);

   localparam int FULL_SCALE_MV = 1300;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_FORCE_REPORT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANGE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_CUT          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_CUT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_CODE         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MID_CODE         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHT_CODE      = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUANT,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_CHECK
   } llsr_state_type;

endpackage

// ===== design/light_level_smoother_reporter.sv =====
// Light level smoother and reporter: quantizer, window memory and averaging divider.
// Flow: an accepted beat is quantized and written to the window, the filled entries are read back
//   one entry a cycle and summed, the bit-serial divider averages the sum, and the result is reported
//   if it moved by the change threshold or a report is forced; no new beat is taken until then.
// Reset: synchronous, active high; control and configuration registers return to their default values,
//   the window fill count and write slot to zero.
`timescale 1ns / 1ps

module light_level_smoother_reporter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] adc_millivolts
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [7:0] reported_level, [15:8] window_average
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [llsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [llsr_pkg::CSR_DATA_W-1:0]   csr_data
);

   llsr_pkg::llsr_state_type state_ff, state_in;

   logic                          force_report_ff;
   logic [7:0]                    change_threshold_ff;
   logic [7:0]                    low_cut_ff;
   logic [7:0]                    high_cut_ff;
   logic [7:0]                    dim_code_ff;
   logic [7:0]                    mid_code_ff;
   logic [7:0]                    bright_code_ff;

   logic [llsr_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [llsr_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [llsr_pkg::IDX_W-1:0]    write_slot_ff, write_slot_in;
   logic [llsr_pkg::CNT_W-1:0]    fill_count_ff, fill_count_in;
   logic [llsr_pkg::CODE_W-1:0]   last_reported_ff, last_reported_in;
   logic [llsr_pkg::IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [llsr_pkg::CODE_W-1:0]   rd_data_ff;
   logic [llsr_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [llsr_pkg::SUM_W-1:0]    sum_total;
   logic [llsr_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [llsr_pkg::AVG_W-1:0]    num_ff, num_in;
   logic [llsr_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]                   rsp_tdata_ff, rsp_tdata_in;

   logic [llsr_pkg::CODE_W-1:0]   win_mem [llsr_pkg::WINDOW];
   logic                          mem_we;

   logic [llsr_pkg::LIM_W-1:0]    lo_lim;
   logic [llsr_pkg::LIM_W-1:0]    hi_lim;
   logic [llsr_pkg::CNT_W:0]      trial;
   logic                          q_bit;
   logic [llsr_pkg::AVG_W-1:0]    gap;
   logic                          report;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         force_report_ff     <= 1'b0;
         change_threshold_ff <= 8'd60;
         low_cut_ff          <= 8'd59;
         high_cut_ff         <= 8'd253;
         dim_code_ff         <= 8'd40;
         mid_code_ff         <= 8'd130;
         bright_code_ff      <= 8'd210;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            llsr_pkg::REG_FORCE_REPORT:     force_report_ff     <= csr_data[0];
            llsr_pkg::REG_CHANGE_THRESHOLD: change_threshold_ff <= csr_data;
            llsr_pkg::REG_LOW_CUT:          low_cut_ff          <= csr_data;
            llsr_pkg::REG_HIGH_CUT:         high_cut_ff         <= csr_data;
            llsr_pkg::REG_DIM_CODE:         dim_code_ff         <= csr_data;
            llsr_pkg::REG_MID_CODE:         mid_code_ff         <= csr_data;
            llsr_pkg::REG_BRIGHT_CODE:      bright_code_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // window memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[write_slot_ff] <= code_in;
      end
      rd_data_ff <= win_mem[rd_idx_ff];
   end

   // scaled <= cut  iff  mv * 255 < (cut + 1) * 1300
   assign lo_lim = (llsr_pkg::LIM_W'(low_cut_ff) + llsr_pkg::LIM_W'(1))
                   * llsr_pkg::LIM_W'(llsr_pkg::FULL_SCALE_MV);
   assign hi_lim = (llsr_pkg::LIM_W'(high_cut_ff) + llsr_pkg::LIM_W'(1))
                   * llsr_pkg::LIM_W'(llsr_pkg::FULL_SCALE_MV);

   assign sum_total = sum_ff + (rd_vld_ff ? llsr_pkg::SUM_W'(rd_data_ff) : '0);
   assign trial     = {rem_ff, num_ff[llsr_pkg::AVG_W-1]};
   assign q_bit     = (trial >= {1'b0, fill_count_ff});
   assign gap       = (num_ff >= last_reported_ff) ? (num_ff - last_reported_ff)
                                                   : (last_reported_ff - num_ff);
   assign report    = (gap >= change_threshold_ff) || force_report_ff;

   always_comb begin
      state_in         = state_ff;
      prod_in          = prod_ff;
      code_in          = code_ff;
      write_slot_in    = write_slot_ff;
      fill_count_in    = fill_count_ff;
      last_reported_in = last_reported_ff;
      rd_idx_in        = rd_idx_ff;
      rd_vld_in        = 1'b0;
      sum_in           = rd_vld_ff ? sum_total : sum_ff;
      rem_in           = rem_ff;
      num_in           = num_ff;
      step_in          = step_ff;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in     = rsp_tdata_ff;
      mem_we           = 1'b0;
      req_tready       = 1'b0;

      case (state_ff)
         llsr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               prod_in  = {req_tdata, 8'h00} - llsr_pkg::PROD_W'(req_tdata);
               state_in = llsr_pkg::ST_QUANT;
            end
         end
         llsr_pkg::ST_QUANT: begin
            if (prod_ff < llsr_pkg::PROD_W'(lo_lim)) begin
               code_in = dim_code_ff;
            end else if (prod_ff < llsr_pkg::PROD_W'(hi_lim)) begin
               code_in = mid_code_ff;
            end else begin
               code_in = bright_code_ff;
            end
            mem_we        = 1'b1;
            write_slot_in = (write_slot_ff == llsr_pkg::IDX_W'(llsr_pkg::WINDOW - 1))
                            ? '0 : write_slot_ff + 1'b1;
            if (fill_count_ff != llsr_pkg::CNT_W'(llsr_pkg::WINDOW)) begin
               fill_count_in = fill_count_ff + 1'b1;
            end
            sum_in    = '0;
            rd_idx_in = '0;
            state_in  = llsr_pkg::ST_READ;
         end
         llsr_pkg::ST_READ: begin
            rd_vld_in = 1'b1;
            if (llsr_pkg::CNT_W'(rd_idx_ff) == fill_count_ff - 1'b1) begin
               state_in = llsr_pkg::ST_LOAD;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         llsr_pkg::ST_LOAD: begin
            rem_in   = sum_total[llsr_pkg::SUM_W-1:llsr_pkg::AVG_W];
            num_in   = sum_total[llsr_pkg::AVG_W-1:0];
            step_in  = '0;
            state_in = llsr_pkg::ST_DIV;
         end
         llsr_pkg::ST_DIV: begin
            rem_in  = q_bit ? llsr_pkg::CNT_W'(trial - {1'b0, fill_count_ff})
                            : llsr_pkg::CNT_W'(trial);
            num_in  = {num_ff[llsr_pkg::AVG_W-2:0], q_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == llsr_pkg::STEP_W'(llsr_pkg::AVG_W - 1)) begin
               state_in = llsr_pkg::ST_CHECK;
            end
         end
         llsr_pkg::ST_CHECK: begin
            if (!report) begin
               state_in = llsr_pkg::ST_IDLE;
            end else if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in    = 1'b1;
               rsp_tdata_in     = {num_ff, code_ff};
               last_reported_in = code_ff;
               state_in         = llsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = llsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= llsr_pkg::ST_IDLE;
         write_slot_ff    <= '0;
         fill_count_ff    <= '0;
         last_reported_ff <= '0;
         rd_vld_ff        <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
         rd_idx_ff        <= '0;
      end else begin
         state_ff         <= state_in;
         write_slot_ff    <= write_slot_in;
         fill_count_ff    <= fill_count_in;
         last_reported_ff <= last_reported_in;
         rd_vld_ff        <= rd_vld_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
         rd_idx_ff        <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      code_ff      <= code_in;
      sum_ff       <= sum_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      step_ff      <= step_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

// ===== design/llsr_checker.sv =====
// Port-level checks for the light level smoother and reporter, with bind.
`timescale 1ns / 1ps

module llsr_assertions (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [15:0]                       rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req beat accepted while previous one in flight");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("rsp beat raised too soon after req beat");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind light_level_smoother_reporter llsr_assertions u_llsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
